[hdl/tcc_pkg.sv]
// Package for the token context classifier: kind and category codes,
// the kind-to-category table and the identifier classification function.
// No dependencies.
package tcc_pkg;

  localparam int unsigned KindW = 6;
  localparam int unsigned CatW  = 4;
  localparam int unsigned QDepth = 4;

  // Token kind codes used by the context rules
  localparam logic [KindW-1:0] KIdent  = 6'd0;
  localparam logic [KindW-1:0] KLParen = 6'd1;
  localparam logic [KindW-1:0] KAssign = 6'd12;
  localparam logic [KindW-1:0] KAt     = 6'd34;
  localparam logic [KindW-1:0] KColon  = 6'd36;
  localparam logic [KindW-1:0] KSemi   = 6'd38;
  localparam logic [KindW-1:0] KRArrow = 6'd39;
  localparam logic [KindW-1:0] KAs     = 6'd40;
  localparam logic [KindW-1:0] KLet    = 6'd41;
  localparam logic [KindW-1:0] KConst  = 6'd42;
  localparam logic [KindW-1:0] KFunc   = 6'd43;

  // Range boundaries of the kind numbering
  localparam logic [KindW-1:0] KBracketLast = 6'd4;
  localparam logic [KindW-1:0] KNumberLast  = 6'd8;
  localparam logic [KindW-1:0] KString      = 6'd9;
  localparam logic [KindW-1:0] KCommentLast = 6'd11;
  localparam logic [KindW-1:0] KOpLast      = 6'd32;
  localparam logic [KindW-1:0] KDArrow      = 6'd33;
  localparam logic [KindW-1:0] KPunctLast   = 6'd39;
  localparam logic [KindW-1:0] KKeywordLast = 6'd51;
  localparam logic [KindW-1:0] KBoolLast    = 6'd53;
  localparam logic [KindW-1:0] KTypeLast    = 6'd58;

  // Highlight categories
  localparam logic [CatW-1:0] CIdent   = 4'd0;
  localparam logic [CatW-1:0] CBracket = 4'd1;
  localparam logic [CatW-1:0] CNumber  = 4'd2;
  localparam logic [CatW-1:0] CString  = 4'd3;
  localparam logic [CatW-1:0] CComment = 4'd4;
  localparam logic [CatW-1:0] COp      = 4'd5;
  localparam logic [CatW-1:0] CError   = 4'd6;
  localparam logic [CatW-1:0] CAnnot   = 4'd7;
  localparam logic [CatW-1:0] CPunct   = 4'd8;
  localparam logic [CatW-1:0] CKeyword = 4'd9;
  localparam logic [CatW-1:0] CBool    = 4'd10;
  localparam logic [CatW-1:0] CType    = 4'd11;
  localparam logic [CatW-1:0] CVar     = 4'd12;
  localparam logic [CatW-1:0] CFunc    = 4'd13;

  // One result beat
  typedef struct packed {
    logic [CatW-1:0] category;
    logic            run_last;
  } res_t;

  // Up to two results pushed into the result queue per token
  typedef struct packed {
    logic push_a;
    logic push_b;
    res_t res_a;
    res_t res_b;
  } push_t;

  // Category and the bias left behind by one classification
  typedef struct packed {
    logic [CatW-1:0] category;
    logic [CatW-1:0] bias;
  } cls_t;

  // Fixed category of a non-identifier kind
  function automatic logic [CatW-1:0] kind_cat(input logic [KindW-1:0] kind);
    logic [CatW-1:0] c;
    if (kind == KIdent)              c = CIdent;
    else if (kind <= KBracketLast)   c = CBracket;
    else if (kind <= KNumberLast)    c = CNumber;
    else if (kind == KString)        c = CString;
    else if (kind <= KCommentLast)   c = CComment;
    else if (kind <= KOpLast)        c = COp;
    else if (kind == KDArrow)        c = CError;
    else if (kind == KAt)            c = CAnnot;
    else if (kind <= KPunctLast)     c = CPunct;
    else if (kind <= KKeywordLast)   c = CKeyword;
    else if (kind <= KBoolLast)      c = CBool;
    else if (kind <= KTypeLast)      c = CType;
    else                             c = CError;
    return c;
  endfunction

  // Classify one token from its neighbours and the current bias
  function automatic cls_t classify(input logic [KindW-1:0] kind,
                                    input logic has_prev,
                                    input logic [KindW-1:0] prev,
                                    input logic has_next,
                                    input logic [KindW-1:0] next,
                                    input logic [CatW-1:0] bias);
    cls_t r;
    r.bias     = bias;
    r.category = bias;
    if (kind != KIdent) begin
      r.category = kind_cat(kind);
    end else if (has_prev && (prev == KLet || prev == KConst)) begin
      r.category = CVar;
      r.bias     = CVar;
    end else if (has_prev && prev == KFunc) begin
      r.category = CFunc;
      r.bias     = CVar;
    end else if (has_prev && (prev == KAs || prev == KColon || prev == KRArrow)) begin
      r.category = CType;
    end else if (has_prev && prev == KAt) begin
      r.category = CAnnot;
      r.bias     = CIdent;
    end else begin
      // semicolon before resets the bias and the lookahead rules go on
      if (has_prev && prev == KSemi) r.bias = CVar;
      r.category = r.bias;
      if (has_next) begin
        if (next == KAssign) begin
          if (!has_prev || prev == KSemi || prev == KIdent) r.category = CVar;
        end else if (next == KColon || next == KAs) begin
          r.category = CVar;
        end else if (next == KLParen) begin
          r.category = CFunc;
        end
      end
    end
    return r;
  endfunction

endpackage

[hdl/tcc_if.sv]
// Valid/ready channel interfaces for token beats and result beats.
// Depends on tcc_pkg.
interface tcc_tok_if;
  import tcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] token_kind;
  logic             stream_end;
  modport source (output valid, token_kind, stream_end, input ready);
  modport sink   (input valid, token_kind, stream_end, output ready);
endinterface

interface tcc_res_if;
  import tcc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CatW-1:0] category;
  logic            run_last;
  modport source (output valid, category, run_last, input ready);
  modport sink   (input valid, category, run_last, output ready);
endinterface

[hdl/tcc_queue.sv]
// Result queue: takes up to two result beats per cycle, gives one per ready cycle.
// Depends on tcc_pkg.
module tcc_queue #(
  parameter int unsigned Depth = tcc_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcc_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output tcc_pkg::res_t  res_o
);
  import tcc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_b;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) r = '0;
    else                       r = p + PtrW'(1);
    return r;
  endfunction

  assign pop      = valid_o && ready_i;
  assign valid_o  = (count_q != '0);
  assign res_o    = mem_q[rd_ptr_q];
  // room for two beats whatever leaves this cycle
  assign room_o   = (count_q <= CntW'(Depth - 2));
  assign n_push   = {1'b0, push_i.push_a} + {1'b0, push_i.push_b};
  assign wr_ptr_b = ptr_inc(wr_ptr_q);

  // advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.push_b)      wr_ptr_d = ptr_inc(wr_ptr_b);
    else if (push_i.push_a) wr_ptr_d = wr_ptr_b;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // write the pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i.push_a) mem_q[wr_ptr_q] <= push_i.res_a;
    if (push_i.push_b) mem_q[wr_ptr_b] <= push_i.res_b;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_b_needs_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_b |-> push_i.push_a)
    else $error("second beat pushed without first");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> $past(room_o) || room_o)
    else $error("push into a queue without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd0 && !pop) |=> $stable(count_q))
    else $error("queue count moved without traffic");

endmodule

[hdl/token_context_classifier.sv]
// Token context classifier: one highlight category per token, identifiers
// classified from the previous token, the next token and a sticky bias.
// A token's result beat is queued when the next token is taken, or with it when it ends a stream.
// Throughput: one token per cycle; an end-of-stream token yields two beats if a token is held.
// The four-entry result queue sets the figure; tokens wait while fewer than two entries are free.
// Reset clears the held tokens, sets the bias to variable and empties the queue.
module token_context_classifier (
  input logic          clk_i,
  input logic          rst_ni,
  tcc_tok_if.sink      tok_i,
  tcc_res_if.source    res_o
);
  import tcc_pkg::*;

  logic [KindW-1:0] held_kind_q, held_kind_d, before_kind_q, before_kind_d;
  logic             held_valid_q, held_valid_d, before_valid_q, before_valid_d;
  logic [CatW-1:0]  bias_q, bias_d, bias_mid;
  logic             accept, room, prev2_valid;
  logic [KindW-1:0] prev2_kind;
  cls_t             cls_held, cls_new;
  push_t            push;
  res_t             res;

  assign tok_i.ready = room;
  assign accept      = tok_i.valid && room;

  // classify the held token with the new one as lookahead
  assign cls_held = classify(held_kind_q, before_valid_q, before_kind_q, 1'b1,
                             tok_i.token_kind, bias_q);
  assign bias_mid = held_valid_q ? cls_held.bias : bias_q;

  // at end of stream classify the new token with no lookahead
  assign prev2_valid = held_valid_q || before_valid_q;
  assign prev2_kind  = held_valid_q ? held_kind_q : before_kind_q;
  assign cls_new     = classify(tok_i.token_kind, prev2_valid, prev2_kind, 1'b0,
                                KIdent, bias_mid);

  // arrange the beats of this token
  always_comb begin
    push = '0;
    if (accept) begin
      if (held_valid_q) begin
        push.push_a            = 1'b1;
        push.res_a.category    = cls_held.category;
        push.res_a.run_last    = !tok_i.stream_end;
        if (tok_i.stream_end) begin
          push.push_b          = 1'b1;
          push.res_b.category  = cls_new.category;
          push.res_b.run_last  = 1'b1;
        end
      end else if (tok_i.stream_end) begin
        push.push_a            = 1'b1;
        push.res_a.category    = cls_new.category;
        push.res_a.run_last    = 1'b1;
      end
    end
  end

  // advance the context
  always_comb begin
    held_kind_d    = held_kind_q;
    held_valid_d   = held_valid_q;
    before_kind_d  = before_kind_q;
    before_valid_d = before_valid_q;
    bias_d         = bias_q;
    if (accept) begin
      if (tok_i.stream_end) begin
        held_kind_d    = KIdent;
        held_valid_d   = 1'b0;
        before_kind_d  = KIdent;
        before_valid_d = 1'b0;
        bias_d         = CVar;
      end else begin
        held_kind_d  = tok_i.token_kind;
        held_valid_d = 1'b1;
        bias_d       = bias_mid;
        if (held_valid_q) begin
          before_kind_d  = held_kind_q;
          before_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_kind_q    <= KIdent;
      held_valid_q   <= 1'b0;
      before_kind_q  <= KIdent;
      before_valid_q <= 1'b0;
      bias_q         <= CVar;
    end else begin
      held_kind_q    <= held_kind_d;
      held_valid_q   <= held_valid_d;
      before_kind_q  <= before_kind_d;
      before_valid_q <= before_valid_d;
      bias_q         <= bias_d;
    end
  end

  tcc_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res)
  );

  assign res_o.category = res.category;
  assign res_o.run_last = res.run_last;

  a_before_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    before_valid_q |-> held_valid_q)
    else $error("predecessor held without a held token");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tok_i.stream_end) |=> !held_valid_q && bias_q == CVar)
    else $error("end of stream did not clear the context");

  a_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !held_valid_q && !tok_i.stream_end) |-> !push.push_a)
    else $error("first token of a stream produced a beat");

endmodule
